// ===== hw/rtl/radial_point_clamp_to_box_assert.svh =====
// Assertion macros used by the point clamp RTL.
`ifndef RADIAL_POINT_CLAMP_TO_BOX_ASSERT_SVH
`define RADIAL_POINT_CLAMP_TO_BOX_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define RPCB_ASSERT_HOLD(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rpcb check failed");

// Condition that must hold whenever a precondition holds.
`define RPCB_ASSERT_IMPLY(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rpcb check failed");

`endif

// ===== hw/rtl/rpcb_pkg.sv =====
// Types and constants for the radial point clamp.
package rpcb_pkg;

  // Quotient bits produced by the divider chain, one per cell.
  localparam int DIV_BITS = 34;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_BOX_X_LOW  = 3'd0;
  localparam logic [2:0] REG_BOX_Y_LOW  = 3'd1;
  localparam logic [2:0] REG_BOX_X_HIGH = 3'd2;
  localparam logic [2:0] REG_BOX_Y_HIGH = 3'd3;
  localparam logic [2:0] REG_CENTER_X   = 3'd4;
  localparam logic [2:0] REG_CENTER_Y   = 3'd5;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } rpcb_in_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic               was_inside;
  } rpcb_out_t;

  // Per-word side data that rides along the divider chain.
  typedef struct packed {
    logic               bypass;
    logic               in_box;
    logic               pick_x;
    logic               ovf;
    logic               neg;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] bound;
    logic signed [31:0] center;
  } rpcb_side_t;

  // Partial remainder, dividend bits still to shift in, quotient so far.
  typedef struct packed {
    logic [32:0]         rem;
    logic [DIV_BITS-1:0] numlo;
    logic [DIV_BITS-1:0] q;
  } rpcb_div_t;

endpackage

// ===== hw/rtl/rpcb_div_cell.sv =====
// One restoring-division cell: produces one quotient bit per word.
module rpcb_div_cell
  import rpcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        v_in,
  input  rpcb_div_t   d_in,
  input  rpcb_side_t  s_in,
  input  logic [32:0] den_in,
  output logic        v_out,
  output rpcb_div_t   d_out,
  output rpcb_side_t  s_out,
  output logic [32:0] den_out
);

  logic        valid_r;
  rpcb_div_t   d_r;
  rpcb_div_t   d_nxt;
  rpcb_side_t  s_r;
  logic [32:0] den_r;
  logic [33:0] trial;
  logic [34:0] diff;
  logic        ge;

  // Shift in the next dividend bit and try subtracting the divisor.
  always_comb begin
    trial       = {d_in.rem, d_in.numlo[DIV_BITS-1]};
    diff        = {1'b0, trial} - {2'b00, den_in};
    ge          = !diff[34];
    d_nxt.rem   = ge ? diff[32:0] : trial[32:0];
    d_nxt.numlo = {d_in.numlo[DIV_BITS-2:0], 1'b0};
    d_nxt.q     = {d_in.q[DIV_BITS-2:0], ge};
  end

  // Valid bit is control state and is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= v_in;
    end
  end

  // Payload moves with the pipeline enable.
  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_nxt;
      s_r   <= s_in;
      den_r <= den_in;
    end
  end

  assign v_out   = valid_r;
  assign d_out   = d_r;
  assign s_out   = s_r;
  assign den_out = den_r;

endmodule

// ===== hw/rtl/radial_point_clamp_to_box.sv =====
// Radial point clamp: a point outside the configured box is pulled along the ray from
// the center onto the box edge; a point inside passes through with was_inside set.
// One word is accepted every cycle unless in_stall holds it; each result passes through three
// stages of offset, multiply and side select, a chain of 34 divider cells, one quotient bit
// per cell, and one output register.
// The whole pipeline holds while a result waits on out_stall. Configuration registers
// sit at byte addresses 0 to 20 and should be written only when no word is in flight.
module radial_point_clamp_to_box
  import rpcb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  rpcb_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rpcb_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "radial_point_clamp_to_box_assert.svh"

  // Configuration registers.
  logic signed [31:0] box_x_low_r, box_y_low_r, box_x_high_r, box_y_high_r;
  logic signed [31:0] center_x_r, center_y_r;
  logic [2:0]         reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_low_r  <= 32'sd0;
      box_y_low_r  <= 32'sd0;
      box_x_high_r <= 32'sd65536;
      box_y_high_r <= 32'sd65536;
      center_x_r   <= 32'sd32768;
      center_y_r   <= 32'sd32768;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BOX_X_LOW:  box_x_low_r  <= pwdata;
        REG_BOX_Y_LOW:  box_y_low_r  <= pwdata;
        REG_BOX_X_HIGH: box_x_high_r <= pwdata;
        REG_BOX_Y_HIGH: box_y_high_r <= pwdata;
        REG_CENTER_X:   center_x_r   <= pwdata;
        REG_CENTER_Y:   center_y_r   <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_BOX_X_LOW:  prdata = box_x_low_r;
      REG_BOX_Y_LOW:  prdata = box_y_low_r;
      REG_BOX_X_HIGH: prdata = box_x_high_r;
      REG_BOX_Y_HIGH: prdata = box_y_high_r;
      REG_CENTER_X:   prdata = center_x_r;
      REG_CENTER_Y:   prdata = center_y_r;
      default:        prdata = 32'd0;
    endcase
  end

  // Global pipeline enable: advance unless the output word is held.
  logic      en;
  logic      out_valid_r;
  rpcb_out_t out_data_r;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Stage A: box test, offsets from the center and the reaches.
  logic               a_valid_r, a_inside_r;
  logic signed [31:0] a_px_r, a_py_r;
  logic signed [32:0] a_dx_r, a_dy_r, a_rx_r, a_ry_r;
  logic signed [32:0] a_dx_nxt, a_dy_nxt, a_rx_nxt, a_ry_nxt;
  logic               a_inside_nxt;

  always_comb begin
    a_inside_nxt = (in_data.point_x >= box_x_low_r) && (in_data.point_x <= box_x_high_r) &&
                   (in_data.point_y >= box_y_low_r) && (in_data.point_y <= box_y_high_r);
    a_dx_nxt = {in_data.point_x[31], in_data.point_x} - {center_x_r[31], center_x_r};
    a_dy_nxt = {in_data.point_y[31], in_data.point_y} - {center_y_r[31], center_y_r};
    a_rx_nxt = (a_dx_nxt > 33'sd0) ? ({box_x_high_r[31], box_x_high_r} -
                                      {center_x_r[31], center_x_r})
                                   : ({center_x_r[31], center_x_r} -
                                      {box_x_low_r[31], box_x_low_r});
    a_ry_nxt = (a_dy_nxt > 33'sd0) ? ({box_y_high_r[31], box_y_high_r} -
                                      {center_y_r[31], center_y_r})
                                   : ({center_y_r[31], center_y_r} -
                                      {box_y_low_r[31], box_y_low_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_inside_r <= a_inside_nxt;
      a_px_r     <= in_data.point_x;
      a_py_r     <= in_data.point_y;
      a_dx_r     <= a_dx_nxt;
      a_dy_r     <= a_dy_nxt;
      a_rx_r     <= a_rx_nxt;
      a_ry_r     <= a_ry_nxt;
    end
  end

  // Stage B: cross products reach times opposite offset magnitude.
  logic               b_valid_r, b_inside_r, b_bypass_r, b_dx_zero_r, b_dy_zero_r;
  logic               b_dx_pos_r, b_dy_pos_r, b_neg_x_r, b_neg_y_r;
  logic [32:0]        b_adx_r, b_ady_r;
  logic signed [31:0] b_px_r, b_py_r;
  logic signed [66:0] b_p1_r, b_p2_r;
  logic [32:0]        a_adx, a_ady;

  assign a_adx = a_dx_r[32] ? 33'(-a_dx_r) : a_dx_r;
  assign a_ady = a_dy_r[32] ? 33'(-a_dy_r) : a_dy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_inside_r  <= a_inside_r;
      b_bypass_r  <= a_inside_r || (a_dx_r == 33'sd0 && a_dy_r == 33'sd0);
      b_dx_zero_r <= (a_dx_r == 33'sd0);
      b_dy_zero_r <= (a_dy_r == 33'sd0);
      b_dx_pos_r  <= (a_dx_r > 33'sd0);
      b_dy_pos_r  <= (a_dy_r > 33'sd0);
      b_neg_y_r   <= a_dy_r[32] != a_rx_r[32];
      b_neg_x_r   <= a_dx_r[32] != a_ry_r[32];
      b_adx_r     <= a_adx;
      b_ady_r     <= a_ady;
      b_px_r      <= a_px_r;
      b_py_r      <= a_py_r;
      b_p1_r      <= a_rx_r * $signed({1'b0, a_ady});
      b_p2_r      <= a_ry_r * $signed({1'b0, a_adx});
    end
  end

  // Stage C: choose the side that is hit and the division operands.
  logic               pick_x;
  logic [66:0]        abs_p1, abs_p2;
  logic               c_valid_r;
  rpcb_side_t         c_side_r, c_side_nxt;
  logic [63:0]        c_num_r;
  logic [32:0]        c_den_r;

  always_comb begin
    pick_x = b_dy_zero_r || (!b_dx_zero_r && (b_p1_r <= b_p2_r));
    abs_p1 = b_p1_r[66] ? 67'(-b_p1_r) : b_p1_r;
    abs_p2 = b_p2_r[66] ? 67'(-b_p2_r) : b_p2_r;
    c_side_nxt.bypass = b_bypass_r;
    c_side_nxt.in_box = b_inside_r;
    c_side_nxt.pick_x = pick_x;
    c_side_nxt.ovf    = 1'b0;
    c_side_nxt.neg    = pick_x ? b_neg_y_r : b_neg_x_r;
    c_side_nxt.px     = b_px_r;
    c_side_nxt.py     = b_py_r;
    if (pick_x) begin
      c_side_nxt.bound  = b_dx_pos_r ? box_x_high_r : box_x_low_r;
      c_side_nxt.center = center_y_r;
    end else begin
      c_side_nxt.bound  = b_dy_pos_r ? box_y_high_r : box_y_low_r;
      c_side_nxt.center = center_x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side_r <= c_side_nxt;
      c_num_r  <= pick_x ? abs_p1[63:0] : abs_p2[63:0];
      c_den_r  <= pick_x ? b_adx_r : b_ady_r;
    end
  end

  // Divider entry: a quotient of 2^34 or more saturates the result anyway.
  logic       [DIV_BITS:0] cv;
  rpcb_div_t  cd  [0:DIV_BITS];
  rpcb_side_t cs  [0:DIV_BITS];
  logic [32:0] cden [0:DIV_BITS];
  logic        ovf;
  rpcb_side_t  c_side_ent;
  rpcb_div_t   c_div_ent;

  always_comb begin
    ovf             = {3'b000, c_num_r[63:DIV_BITS]} >= c_den_r;
    c_side_ent      = c_side_r;
    c_side_ent.ovf  = ovf;
    c_div_ent.rem   = ovf ? 33'd0 : {3'b000, c_num_r[63:DIV_BITS]};
    c_div_ent.numlo = c_num_r[DIV_BITS-1:0];
    c_div_ent.q     = '0;
  end

  assign cv[0]   = c_valid_r;
  assign cs[0]   = c_side_ent;
  assign cd[0]   = c_div_ent;
  assign cden[0] = c_den_r;

  // Chain of division cells.
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_cell
    rpcb_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (cv[k]),
      .d_in    (cd[k]),
      .s_in    (cs[k]),
      .den_in  (cden[k]),
      .v_out   (cv[k+1]),
      .d_out   (cd[k+1]),
      .s_out   (cs[k+1]),
      .den_out (cden[k+1])
    );
  end

  // Final stage: add the scaled offset to the center and saturate.
  rpcb_side_t         fs;
  logic [DIV_BITS:0]  mag;
  logic signed [36:0] sum;
  logic signed [31:0] sat;
  rpcb_out_t          out_nxt;

  always_comb begin
    fs  = cs[DIV_BITS];
    mag = fs.ovf ? {1'b1, {DIV_BITS{1'b0}}} : {1'b0, cd[DIV_BITS].q};
    sum = {{5{fs.center[31]}}, fs.center} +
          (fs.neg ? 37'(-{2'b00, mag}) : {2'b00, mag});
    if (sum > 37'sd2147483647) begin
      sat = 32'sh7fffffff;
    end else if (sum < -37'sd2147483648) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[31:0];
    end
    out_nxt.was_inside = fs.in_box;
    if (fs.bypass) begin
      out_nxt.result_x = fs.px;
      out_nxt.result_y = fs.py;
    end else if (fs.pick_x) begin
      out_nxt.result_x = fs.bound;
      out_nxt.result_y = sat;
    end else begin
      out_nxt.result_x = sat;
      out_nxt.result_y = fs.bound;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cv[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  // Whether the held output word lies within the box.
  logic out_in_box;

  assign out_in_box = (out_data_r.result_x >= box_x_low_r) &&
                      (out_data_r.result_x <= box_x_high_r) &&
                      (out_data_r.result_y >= box_y_low_r) &&
                      (out_data_r.result_y <= box_y_high_r);

  // Checks on the divider invariants and on the pass-through case.
  `RPCB_ASSERT_IMPLY(a_div_entry, c_valid_r && !c_side_r.bypass && !ovf, cd[0].rem < c_den_r)
  `RPCB_ASSERT_IMPLY(a_div_exit, cv[DIV_BITS] && !fs.bypass, cd[DIV_BITS].rem < cden[DIV_BITS])
  `RPCB_ASSERT_IMPLY(a_inside_box, out_valid_r && out_data_r.was_inside, out_in_box)

endmodule

// ===== bench/tb_radial_point_clamp_to_box.sv =====
// Testbench for the radial point clamp: directed table, then random points checked by a predictor.
module tb_radial_point_clamp_to_box
  import rpcb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  LATENCY     = 37;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  rpcb_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  rpcb_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  radial_point_clamp_to_box uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Copy of the box and center as the block should hold them.
  longint box_xl = 0, box_yl = 0, box_xh = 65536, box_yh = 65536;
  longint ctr_x = 32768, ctr_y = 32768;

  rpcb_out_t clamped_q[$];
  int        errors = 0;
  int        cycles = 0;
  bit        quiet = 1'b0;
  int        stall_left = 0;

  typedef struct {
    rpcb_in_t  pt;
    bit        known;
    rpcb_out_t res;
  } row_t;
  row_t rows[$];

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Sign of a*ma - b*mb with 64-bit wrapping products.
  function automatic int side_order(longint a, longint unsigned ma, longint b,
                                    longint unsigned mb);
    longint unsigned pa, pb;
    bit na, nb;
    pa = mag(a) * ma;
    pb = mag(b) * mb;
    na = (a < 0) && (pa != 0);
    nb = (b < 0) && (pb != 0);
    if (na != nb) return na ? -1 : 1;
    if (pa == pb) return 0;
    if (!na) return pa < pb ? -1 : 1;
    return pa > pb ? -1 : 1;
  endfunction

  // Truncated off*reach/den, magnitude capped at 2^34.
  function automatic longint scaled_offset(longint off, longint reach, longint unsigned den);
    longint unsigned m;
    bit neg;
    m = mag(off) * mag(reach) / den;
    neg = (off < 0) != (reach < 0);
    if (m > (64'd1 << 34)) m = 64'd1 << 34;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic rpcb_out_t clamp_point(rpcb_in_t p);
    longint px, py, dx, dy, rx, ry, ox, oy;
    bit pick_x;
    rpcb_out_t r;
    px = p.point_x;
    py = p.point_y;
    r.was_inside = 1'b0;
    if (px >= box_xl && px <= box_xh && py >= box_yl && py <= box_yh) begin
      ox = px;
      oy = py;
      r.was_inside = 1'b1;
    end else begin
      dx = px - ctr_x;
      dy = py - ctr_y;
      if (dx == 0 && dy == 0) begin
        ox = px;
        oy = py;
      end else begin
        rx = dx > 0 ? box_xh - ctr_x : ctr_x - box_xl;
        ry = dy > 0 ? box_yh - ctr_y : ctr_y - box_yl;
        if (dy == 0) pick_x = 1'b1;
        else if (dx == 0) pick_x = 1'b0;
        else pick_x = side_order(rx, mag(dy), ry, mag(dx)) <= 0;
        if (pick_x) begin
          ox = dx > 0 ? box_xh : box_xl;
          oy = sat32(ctr_y + scaled_offset(dy, rx, mag(dx)));
        end else begin
          oy = dy > 0 ? box_yh : box_yl;
          ox = sat32(ctr_x + scaled_offset(dx, ry, mag(dy)));
        end
      end
    end
    r.result_x = ox[31:0];
    r.result_y = oy[31:0];
    return r;
  endfunction

  // Cycle limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: stall at random and check every accepted word.
  always @(posedge clk) begin
    int n;
    rpcb_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (clamped_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $realtime, out_data);
        end else begin
          want = clamped_q.pop_front();
          if (out_data.result_x !== want.result_x) begin
            errors++;
            $display("%0t: result_x expected %h actual %h", $realtime, want.result_x,
                     out_data.result_x);
          end
          if (out_data.result_y !== want.result_y) begin
            errors++;
            $display("%0t: result_y expected %h actual %h", $realtime, want.result_y,
                     out_data.result_y);
          end
          if (out_data.was_inside !== want.was_inside) begin
            errors++;
            $display("%0t: was_inside expected %b actual %b", $realtime, want.was_inside,
                     out_data.was_inside);
          end
        end
        n = quiet ? 0 : $urandom_range(0, 17);
      end else begin
        n = stall_left > 0 ? stall_left - 1 : 0;
      end
      stall_left <= n;
      out_stall <= (n != 0);
    end
  end

  task automatic write_reg(logic [2:0] idx, longint val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val[31:0];
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BOX_X_LOW:  box_xl = longint'($signed(val[31:0]));
      REG_BOX_Y_LOW:  box_yl = longint'($signed(val[31:0]));
      REG_BOX_X_HIGH: box_xh = longint'($signed(val[31:0]));
      REG_BOX_Y_HIGH: box_yh = longint'($signed(val[31:0]));
      REG_CENTER_X:   ctr_x = longint'($signed(val[31:0]));
      REG_CENTER_Y:   ctr_y = longint'($signed(val[31:0]));
      default: ;
    endcase
  endtask

  task automatic set_box(longint xl, longint yl, longint xh, longint yh, longint cx,
                         longint cy);
    write_reg(REG_BOX_X_LOW, xl);
    write_reg(REG_BOX_Y_LOW, yl);
    write_reg(REG_BOX_X_HIGH, xh);
    write_reg(REG_BOX_Y_HIGH, yh);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
  endtask

  // Offer one word, wait for it to be taken, and record what it should produce.
  task automatic send_point(rpcb_in_t p, bit known, rpcb_out_t res);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    clamped_q.push_back(known ? res : clamp_point(p));
  endtask

  // Stop sending and let every word in flight come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (clamped_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  task automatic add_row(longint px, longint py, bit known, longint rx, longint ry,
                         bit ins);
    row_t r;
    r.pt.point_x = px[31:0];
    r.pt.point_y = py[31:0];
    r.known = known;
    r.res.result_x = rx[31:0];
    r.res.result_y = ry[31:0];
    r.res.was_inside = ins;
    rows.push_back(r);
  endtask

  task automatic run_rows();
    foreach (rows[i]) send_point(rows[i].pt, rows[i].known, rows[i].res);
    rows.delete();
    drain();
  endtask

  function automatic longint rand_coord(longint lo, longint hi, longint c);
    longint span, v;
    span = hi - lo;
    case ($urandom_range(0, 5))
      0: v = longint'($signed($urandom()));
      1: v = lo - 4 + $urandom_range(0, 8);
      2: v = hi - 4 + $urandom_range(0, 8);
      3: v = c - 4 + $urandom_range(0, 8);
      default: begin
        if (span > 0 && span < 64'sd1000000000)
          v = lo - span + longint'($urandom_range(0, 32'(3 * span)));
        else
          v = longint'($signed($urandom())) >>> $urandom_range(0, 31);
      end
    endcase
    return sat32(v);
  endfunction

  // One axis of a box with its center inside it.
  task automatic pick_axis(output longint lo, output longint hi, output longint c);
    longint w;
    lo = longint'($signed($urandom())) >>> $urandom_range(0, 31);
    w = longint'($urandom()) >> $urandom_range(0, 31);
    hi = sat32(lo + w);
    c = lo + ((hi > lo) ? longint'($urandom()) % (hi - lo + 1) : 0);
  endtask

  function automatic longint pick_extreme();
    case ($urandom_range(0, 3))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return 0;
      default: return longint'($signed($urandom()));
    endcase
  endfunction

  initial begin
    longint xl, xh, xc, yl, yh, yc;
    rpcb_in_t p;
    rpcb_out_t none;
    none = '0;
    rst_n = 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Box and center as they come out of reset.
    add_row(0, 0, 1, 0, 0, 1);
    add_row(65536, 65536, 1, 65536, 65536, 1);
    add_row(S32_MAX, 32768, 1, 65536, 32768, 0);
    add_row(S32_MIN, 32768, 1, 0, 32768, 0);
    add_row(32768, S32_MAX, 1, 32768, 65536, 0);
    add_row(32768, S32_MIN, 1, 32768, 0, 0);
    add_row(1081344, 1081344, 1, 65536, 65536, 0);
    add_row(-1015808, -1015808, 1, 0, 0, 0);
    add_row(S32_MAX, S32_MAX, 0, 0, 0, 0);
    add_row(S32_MIN, S32_MAX, 0, 0, 0, 0);
    add_row(200000, 40000, 0, 0, 0, 0);
    add_row(-3, 70001, 0, 0, 0, 0);
    add_row(65537, 65536, 0, 0, 0, 0);
    run_rows();

    // Center outside the box: the center itself comes back untouched.
    set_box(0, 0, 65536, 65536, 1048576, 1048576);
    add_row(1048576, 1048576, 1, 1048576, 1048576, 0);
    add_row(S32_MIN, S32_MIN, 0, 0, 0, 0);
    add_row(-5, 99999, 0, 0, 0, 0);
    run_rows();

    // Box over the whole range: everything lies inside.
    set_box(S32_MIN, S32_MIN, S32_MAX, S32_MAX, 0, 0);
    add_row(S32_MIN, S32_MAX, 1, S32_MIN, S32_MAX, 1);
    add_row(S32_MAX, S32_MIN, 1, S32_MAX, S32_MIN, 1);
    run_rows();

    // Empty box with far center, where reaches turn negative and sums saturate.
    set_box(S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN, S32_MAX);
    add_row(S32_MAX, S32_MIN, 0, 0, 0, 0);
    add_row(0, 1, 0, 0, 0, 0);
    add_row(S32_MIN + 1, S32_MAX - 1, 0, 0, 0, 0);
    run_rows();

    // Random phases under a mix of box settings.
    for (int ph = 0; ph < 9; ph++) begin
      quiet = (ph % 3 == 1);
      case ($urandom_range(0, 3))
        0, 1: begin
          pick_axis(xl, xh, xc);
          pick_axis(yl, yh, yc);
        end
        2: begin
          xl = longint'($signed($urandom())); xh = longint'($signed($urandom()));
          yl = longint'($signed($urandom())); yh = longint'($signed($urandom()));
          xc = longint'($signed($urandom())); yc = longint'($signed($urandom()));
        end
        default: begin
          xl = pick_extreme(); xh = pick_extreme(); yl = pick_extreme();
          yh = pick_extreme(); xc = pick_extreme(); yc = pick_extreme();
        end
      endcase
      set_box(xl, yl, xh, yh, xc, yc);
      for (int k = 0; k < 200; k++) begin
        p.point_x = 32'(rand_coord(box_xl, box_xh, ctr_x));
        p.point_y = 32'(rand_coord(box_yl, box_yh, ctr_y));
        send_point(p, 1'b0, none);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
